>>> sv/c8x_pkg.sv
package c8x_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,  OP_EOR = 6'd4,
      OP_ASL = 6'd5,  OP_LSR = 6'd6,  OP_ROL = 6'd7,  OP_ROR = 6'd8,
      OP_BIT = 6'd9,  OP_CMP = 6'd10, OP_CPX = 6'd11, OP_CPY = 6'd12,
      OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15, OP_INY = 6'd16,
      OP_DEX = 6'd17, OP_DEY = 6'd18,
      OP_LDA = 6'd19, OP_LDX = 6'd20, OP_LDY = 6'd21,
      OP_STA = 6'd22, OP_STX = 6'd23, OP_STY = 6'd24,
      OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27, OP_TYA = 6'd28,
      OP_TSX = 6'd29, OP_TXS = 6'd30,
      OP_CLC = 6'd31, OP_SEC = 6'd32, OP_CLI = 6'd33, OP_SEI = 6'd34,
      OP_CLV = 6'd35, OP_CLD = 6'd36, OP_SED = 6'd37,
      OP_PHA = 6'd38, OP_PHP = 6'd39, OP_PLA = 6'd40, OP_PLP = 6'd41,
      OP_BCC = 6'd42, OP_BCS = 6'd43, OP_BEQ = 6'd44, OP_BNE = 6'd45,
      OP_BMI = 6'd46, OP_BPL = 6'd47, OP_BVC = 6'd48, OP_BVS = 6'd49,
      OP_NOP = 6'd50
   } op_type;

   localparam logic [1:0] STK_NONE = 2'd0;
   localparam logic [1:0] STK_PUSH = 2'd1;
   localparam logic [1:0] STK_PULL = 2'd2;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] SP_RESET     = 8'hFD;
   localparam logic [7:0] STATUS_RESET = 8'h24;
   localparam logic [8:0] STACK_PAGE   = 9'h100;

   typedef struct packed {
      logic [5:0] op;
      logic [7:0] operand;
      logic       acc_mode;
   } req_type;

   typedef struct packed {
      logic       mem_write;
      logic [7:0] write_value;
      logic [1:0] stack_op;
      logic [8:0] stack_address;
      logic       branch_taken;
      logic [7:0] acc_out;
      logic [7:0] x_out;
      logic [7:0] y_out;
      logic [7:0] sp_out;
      logic [7:0] status_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
   } regs_type;

endpackage

>>> sv/c8x_if.sv
interface c8x_req_if;
   import c8x_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface c8x_rsp_if;
   import c8x_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/c8x_alu.sv
module c8x_alu (
   input  c8x_pkg::req_type  req,
   input  c8x_pkg::regs_type regs,
   output c8x_pkg::regs_type regs_next,
   output c8x_pkg::rsp_type  rsp
);
   import c8x_pkg::*;

   logic [8:0] sum;
   logic [7:0] addend, r, v, cmp_reg, cmp_diff;
   logic       c;

   always_comb begin
      c = regs.p[FLAG_C];
      addend = (req.op == OP_SBC) ? ~req.operand : req.operand;
      sum = {1'b0, regs.a} + {1'b0, addend} + {8'd0, c};
      r = sum[7:0];
      v = req.acc_mode ? regs.a : req.operand;
      cmp_reg = (req.op == OP_CPX) ? regs.x : (req.op == OP_CPY) ? regs.y : regs.a;
      cmp_diff = cmp_reg - req.operand;

      regs_next = regs;
      rsp = '0;
      rsp.stack_address = STACK_PAGE;
      case (req.op)
         OP_ADC, OP_SBC: begin
            regs_next.p[FLAG_C] = sum[8];
            regs_next.p[FLAG_V] = (regs.a[7] == addend[7]) && (regs.a[7] != r[7]);
            regs_next.a = r;
         end
         OP_AND: regs_next.a = regs.a & req.operand;
         OP_ORA: regs_next.a = regs.a | req.operand;
         OP_EOR: regs_next.a = regs.a ^ req.operand;
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            case (req.op)
               OP_ASL: begin regs_next.p[FLAG_C] = v[7]; v = {v[6:0], 1'b0}; end
               OP_ROL: begin regs_next.p[FLAG_C] = v[7]; v = {v[6:0], c}; end
               OP_LSR: begin regs_next.p[FLAG_C] = v[0]; v = {1'b0, v[7:1]}; end
               default: begin regs_next.p[FLAG_C] = v[0]; v = {c, v[7:1]}; end
            endcase
            if (req.acc_mode) regs_next.a = v;
            else begin rsp.mem_write = 1'b1; rsp.write_value = v; end
         end
         OP_BIT: begin
            regs_next.p[FLAG_V] = req.operand[6];
            regs_next.p[FLAG_N] = req.operand[7];
            regs_next.p[FLAG_Z] = (req.operand & regs.a) == 8'd0;
         end
         OP_CMP, OP_CPX, OP_CPY: regs_next.p[FLAG_C] = cmp_reg >= req.operand;
         OP_INC: begin rsp.mem_write = 1'b1; rsp.write_value = req.operand + 8'd1; end
         OP_DEC: begin rsp.mem_write = 1'b1; rsp.write_value = req.operand - 8'd1; end
         OP_INX: regs_next.x = regs.x + 8'd1;
         OP_INY: regs_next.y = regs.y + 8'd1;
         OP_DEX: regs_next.x = regs.x - 8'd1;
         OP_DEY: regs_next.y = regs.y - 8'd1;
         OP_LDA, OP_PLA: regs_next.a = req.operand;
         OP_LDX: regs_next.x = req.operand;
         OP_LDY: regs_next.y = req.operand;
         OP_STA: begin rsp.mem_write = 1'b1; rsp.write_value = regs.a; end
         OP_STX: begin rsp.mem_write = 1'b1; rsp.write_value = regs.x; end
         OP_STY: begin rsp.mem_write = 1'b1; rsp.write_value = regs.y; end
         OP_TAX: regs_next.x = regs.a;
         OP_TAY: regs_next.y = regs.a;
         OP_TXA: regs_next.a = regs.x;
         OP_TYA: regs_next.a = regs.y;
         OP_TSX: regs_next.x = regs.sp;
         OP_TXS: regs_next.sp = regs.x;
         OP_CLC: regs_next.p[FLAG_C] = 1'b0;
         OP_SEC: regs_next.p[FLAG_C] = 1'b1;
         OP_CLI: regs_next.p[FLAG_I] = 1'b0;
         OP_SEI: regs_next.p[FLAG_I] = 1'b1;
         OP_CLV: regs_next.p[FLAG_V] = 1'b0;
         OP_CLD: regs_next.p[FLAG_D] = 1'b0;
         OP_SED: regs_next.p[FLAG_D] = 1'b1;
         OP_BCC: rsp.branch_taken = !regs.p[FLAG_C];
         OP_BCS: rsp.branch_taken = regs.p[FLAG_C];
         OP_BEQ: rsp.branch_taken = regs.p[FLAG_Z];
         OP_BNE: rsp.branch_taken = !regs.p[FLAG_Z];
         OP_BMI: rsp.branch_taken = regs.p[FLAG_N];
         OP_BPL: rsp.branch_taken = !regs.p[FLAG_N];
         OP_BVC: rsp.branch_taken = !regs.p[FLAG_V];
         OP_BVS: rsp.branch_taken = regs.p[FLAG_V];
         default: ;
      endcase

      // stack traffic
      if (req.op == OP_PHA || req.op == OP_PHP) begin
         rsp.write_value = (req.op == OP_PHA) ? regs.a : (regs.p | 8'h10);
         rsp.stack_op = STK_PUSH;
         rsp.stack_address = STACK_PAGE | {1'b0, regs.sp};
         regs_next.sp = regs.sp - 8'd1;
      end
      if (req.op == OP_PLA || req.op == OP_PLP) begin
         regs_next.sp = regs.sp + 8'd1;
         rsp.stack_op = STK_PULL;
         rsp.stack_address = STACK_PAGE | {1'b0, regs_next.sp};
      end
      if (req.op == OP_PLP) regs_next.p = (req.operand & 8'hEF) | 8'h20;

      // zero and negative from the value each op reports
      case (req.op)
         OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR, OP_LDA, OP_PLA, OP_TXA, OP_TYA: begin
            regs_next.p[FLAG_Z] = regs_next.a == 8'd0;
            regs_next.p[FLAG_N] = regs_next.a[7];
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            regs_next.p[FLAG_Z] = v == 8'd0;
            regs_next.p[FLAG_N] = v[7];
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            regs_next.p[FLAG_Z] = cmp_diff == 8'd0;
            regs_next.p[FLAG_N] = cmp_diff[7];
         end
         OP_INC, OP_DEC: begin
            regs_next.p[FLAG_Z] = rsp.write_value == 8'd0;
            regs_next.p[FLAG_N] = rsp.write_value[7];
         end
         OP_INX, OP_DEX, OP_LDX, OP_TAX, OP_TSX: begin
            regs_next.p[FLAG_Z] = regs_next.x == 8'd0;
            regs_next.p[FLAG_N] = regs_next.x[7];
         end
         OP_INY, OP_DEY, OP_LDY, OP_TAY: begin
            regs_next.p[FLAG_Z] = regs_next.y == 8'd0;
            regs_next.p[FLAG_N] = regs_next.y[7];
         end
         default: ;
      endcase

      rsp.acc_out = regs_next.a;
      rsp.x_out = regs_next.x;
      rsp.y_out = regs_next.y;
      rsp.sp_out = regs_next.sp;
      rsp.status_out = regs_next.p;
   end
endmodule

>>> sv/cpu8_instruction_execute_unit.sv
// Executes one 8-bit CPU instruction per item, one item per cycle sustained while
// the result side is not stalled. An accepted item is held in an input register;
// from there the ALU updates A, X, Y, SP and status and loads the result register,
// which takes a new result whenever it is empty or being drained.
// Decimal mode has no effect; reset gives SP 0xFD and status 0x24.
module cpu8_instruction_execute_unit (
   input logic  clock,
   input logic  reset,
   c8x_req_if.sink   req,
   c8x_rsp_if.source rsp
);
   import c8x_pkg::*;

   req_type  in_ff;
   logic     in_valid_ff;
   rsp_type  out_ff;
   logic     out_valid_ff;
   regs_type regs_ff, regs_in;
   rsp_type  alu_rsp;
   logic     advance;

   // the input stage moves on when the result register is free
   assign advance = !out_valid_ff || rsp.ready;
   assign req.ready = advance || !in_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   c8x_alu u_alu (.req(in_ff), .regs(regs_ff), .regs_next(regs_in), .rsp(alu_rsp));

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (req.ready) in_valid_ff <= req.valid;
      if (req.ready && req.valid) in_ff <= req.data;
   end

   // architectural registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{a: 8'd0, x: 8'd0, y: 8'd0, sp: SP_RESET, p: STATUS_RESET};
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) regs_ff <= regs_in;
      end
      if (advance && in_valid_ff) out_ff <= alu_rsp;
   end
endmodule

>>> sv/c8x_checker.sv
module c8x_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input c8x_pkg::rsp_type rsp_data
);
   import c8x_pkg::*;

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a push always uses the pre-decrement stack pointer
   a_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stack_op == STK_PUSH |->
         rsp_data.stack_address[7:0] == rsp_data.sp_out + 8'd1)
      else $error("push address mismatch");

   // a pull addresses the new stack pointer
   a_pull: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stack_op == STK_PULL |->
         rsp_data.stack_address[7:0] == rsp_data.sp_out)
      else $error("pull address mismatch");

   // no stack op means the page base address
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stack_op == STK_NONE |-> rsp_data.stack_address == STACK_PAGE)
      else $error("idle stack address");

   // input is never refused while the result register is empty
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
endmodule

bind cpu8_instruction_execute_unit c8x_checker u_c8x_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
